@@ src/framed_packet_receiver_queue_assert.svh @@
// Assertion macros of the framed packet receiver queue RTL.
`ifndef FRAMED_PACKET_RECEIVER_QUEUE_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPRQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FPRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/fprq_pkg.sv @@
// Package with sizes, codes and helpers of the framed packet receiver queue.
package fprq_pkg;

    localparam int BUFFER_BYTES = 32;
    localparam int QUEUE_DEPTH  = 4;

    localparam int IDX_W   = $clog2(BUFFER_BYTES);
    localparam int SLOT_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int QADDR_W = $clog2(QUEUE_DEPTH * BUFFER_BYTES);

    localparam int POS_W  = 5;
    localparam int LEN_W  = 5;
    localparam int WAIT_W = 3;

    localparam int APB_ADDR_W = 3;

    localparam logic [7:0]  START_BYTE    = 8'h02;
    localparam logic [7:0]  END_BYTE      = 8'h03;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    localparam logic [0:0] REG_TIMEOUT = 1'b0;

    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_POP  = 2'd2;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] res;
        if (slot == SLOT_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = slot + 1'b1;
        end
        return res;
    endfunction

    function automatic logic [QADDR_W-1:0] queue_addr(input logic [SLOT_W-1:0] slot,
                                                      input logic [IDX_W-1:0]  idx);
        return QADDR_W'(slot) * QADDR_W'(BUFFER_BYTES) + QADDR_W'(idx);
    endfunction

endpackage

@@ src/fprq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module fprq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                         aclk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ src/framed_packet_receiver_queue.sv @@
// Framed packet receiver: frame parser, checksum check and a message queue in RAM.
// The input channel carries one request per transaction: a received byte, a
// time tick or a pop of the oldest stored message. Bytes and ticks produce no
// result; a pop produces one result per payload byte, or a single result
// flagged empty when no message is stored.
// The byte that completes a valid frame then copies the payload from the frame
// RAM into the queue RAM at one byte per cycle; the block stays busy until the
// copy is done. A pop reads its payload bytes one at a time, paced by the queue
// RAM's registered read, and the block stays busy until its last result is
// registered. A full queue drops its oldest message on commit.
// The output register holds a result until it is taken; a stalled receiver
// only holds the pop in progress, while byte and tick transactions are still
// accepted as long as no pop or copy is running.
// Reset returns the parser to waiting for a start byte, empties the queue and
// sets the timeout to 100 ticks; RAM contents are not cleared.
// timeout_ticks is at byte address 0 of the APB port.
module framed_packet_receiver_queue
    import fprq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_req_type,
    input  logic [7:0]            s_rx_byte,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_payload_byte,
    output logic [POS_W-1:0]      m_byte_position,
    output logic [LEN_W-1:0]      m_message_length,
    output logic                  m_last,
    output logic                  m_queue_empty,
    output logic [WAIT_W-1:0]     m_messages_waiting,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

`include "framed_packet_receiver_queue_assert.svh"

    typedef enum logic [2:0] {PH_WAIT, PH_LEN, PH_PAYLOAD, PH_CSUM, PH_END} phase_t;
    typedef enum logic [2:0] {ST_IDLE, ST_COMMIT, ST_POP_RD, ST_POP_OUT, ST_EMPTY} state_t;

    state_t             state_reg,       state_next;
    phase_t             phase_reg,       phase_next;
    logic [IDX_W-1:0]   frame_len_reg,   frame_len_next;
    logic [IDX_W-1:0]   frame_idx_reg,   frame_idx_next;
    logic [7:0]         sum_reg,         sum_next;
    logic [15:0]        idle_reg,        idle_next;
    logic [15:0]        timeout_reg,     timeout_next;
    logic [SLOT_W-1:0]  head_reg,        head_next;
    logic [SLOT_W-1:0]  tail_reg,        tail_next;
    logic [CNT_W-1:0]   count_reg,       count_next;
    logic [IDX_W-1:0]   copy_cnt_reg,    copy_cnt_next;
    logic [SLOT_W-1:0]  pop_slot_reg,    pop_slot_next;
    logic [IDX_W-1:0]   pop_len_reg,     pop_len_next;
    logic [IDX_W-1:0]   pop_idx_reg,     pop_idx_next;
    logic [CNT_W-1:0]   pop_left_reg,    pop_left_next;
    logic [IDX_W-1:0]   lengths_reg [QUEUE_DEPTH];
    logic [IDX_W-1:0]   lengths_next [QUEUE_DEPTH];

    logic               m_valid_reg,     m_valid_next;
    logic [7:0]         m_byte_reg,      m_byte_next;
    logic [POS_W-1:0]   m_pos_reg,       m_pos_next;
    logic [LEN_W-1:0]   m_len_reg,       m_len_next;
    logic               m_last_reg,      m_last_next;
    logic               m_empty_reg,     m_empty_next;
    logic [WAIT_W-1:0]  m_wait_reg,      m_wait_next;

    logic               s_fire;
    logic               out_free;
    logic               cfg_write;
    logic               last_byte;
    logic [15:0]        idle_inc;
    logic [7:0]         byte_sum;

    logic               fr_we;
    logic [7:0]         fr_rdata;
    logic               q_we;
    logic [QADDR_W-1:0] q_waddr;
    logic [QADDR_W-1:0] q_raddr;
    logic [7:0]         q_rdata;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_TIMEOUT) ? {16'd0, timeout_reg} : 32'd0;

    assign last_byte = (pop_idx_reg == IDX_W'(pop_len_reg - 1'b1));
    assign idle_inc  = (idle_reg != 16'hFFFF) ? idle_reg + 16'd1 : idle_reg;
    assign byte_sum  = sum_reg + s_rx_byte;

    assign fr_we   = s_fire && (s_req_type == REQ_BYTE) && (phase_reg == PH_PAYLOAD);
    assign q_we    = (state_reg == ST_COMMIT) && (copy_cnt_reg != '0);
    assign q_waddr = queue_addr(head_reg, IDX_W'(copy_cnt_reg - 1'b1));
    assign q_raddr = queue_addr(pop_slot_reg, pop_idx_reg);

    fprq_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_BYTES)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (fr_we),
        .wr_addr (frame_idx_reg),
        .wr_data (s_rx_byte),
        .rd_addr (copy_cnt_reg),
        .rd_data (fr_rdata)
    );

    fprq_ram #(
        .WIDTH(8),
        .DEPTH(QUEUE_DEPTH * BUFFER_BYTES)
    ) u_queue_ram (
        .aclk    (aclk),
        .wr_en   (q_we),
        .wr_addr (q_waddr),
        .wr_data (fr_rdata),
        .rd_addr (q_raddr),
        .rd_data (q_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        frame_len_next = frame_len_reg;
        frame_idx_next = frame_idx_reg;
        sum_next       = sum_reg;
        idle_next      = idle_reg;
        timeout_next   = timeout_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        copy_cnt_next  = copy_cnt_reg;
        pop_slot_next  = pop_slot_reg;
        pop_len_next   = pop_len_reg;
        pop_idx_next   = pop_idx_reg;
        pop_left_next  = pop_left_reg;
        lengths_next   = lengths_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_byte_next    = m_byte_reg;
        m_pos_next     = m_pos_reg;
        m_len_next     = m_len_reg;
        m_last_next    = m_last_reg;
        m_empty_next   = m_empty_reg;
        m_wait_next    = m_wait_reg;

        if (cfg_write && (paddr[APB_ADDR_W-1:2] == REG_TIMEOUT)) begin
            timeout_next = pwdata[15:0];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (s_req_type)
                        REQ_BYTE: begin
                            idle_next = '0;
                            unique case (phase_reg)
                                PH_WAIT: begin
                                    if (s_rx_byte == START_BYTE) begin
                                        phase_next = PH_LEN;
                                    end
                                end
                                PH_LEN: begin
                                    if ((s_rx_byte == 8'd0) ||
                                        ({1'b0, s_rx_byte} > 9'(BUFFER_BYTES - 1))) begin
                                        phase_next = PH_WAIT;
                                    end else begin
                                        frame_len_next = IDX_W'(s_rx_byte);
                                        frame_idx_next = '0;
                                        sum_next       = '0;
                                        phase_next     = PH_PAYLOAD;
                                    end
                                end
                                PH_PAYLOAD: begin
                                    frame_idx_next = frame_idx_reg + 1'b1;
                                    sum_next       = byte_sum;
                                    if (frame_idx_reg == IDX_W'(frame_len_reg - 1'b1)) begin
                                        phase_next = PH_CSUM;
                                    end
                                end
                                PH_CSUM: begin
                                    sum_next   = byte_sum;
                                    phase_next = PH_END;
                                end
                                PH_END: begin
                                    if ((s_rx_byte == END_BYTE) && (sum_reg == 8'd0)) begin
                                        copy_cnt_next = '0;
                                        state_next    = ST_COMMIT;
                                    end
                                    phase_next = PH_WAIT;
                                end
                                default: begin
                                    phase_next = PH_WAIT;
                                end
                            endcase
                        end
                        REQ_TICK: begin
                            idle_next = idle_inc;
                            if ((phase_reg != PH_WAIT) && (idle_inc > timeout_reg)) begin
                                phase_next = PH_WAIT;
                            end
                        end
                        REQ_POP: begin
                            if (count_reg == '0) begin
                                state_next = ST_EMPTY;
                            end else begin
                                pop_slot_next = tail_reg;
                                pop_len_next  = lengths_reg[tail_reg];
                                pop_idx_next  = '0;
                                pop_left_next = count_reg - 1'b1;
                                tail_next     = slot_inc(tail_reg);
                                count_next    = count_reg - 1'b1;
                                state_next    = ST_POP_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_COMMIT: begin
                if (copy_cnt_reg == frame_len_reg) begin
                    lengths_next[head_reg] = frame_len_reg;
                    head_next              = slot_inc(head_reg);
                    if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                        tail_next = slot_inc(tail_reg);
                    end else begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end else begin
                    copy_cnt_next = copy_cnt_reg + 1'b1;
                end
            end
            ST_POP_RD: begin
                state_next = ST_POP_OUT;
            end
            ST_POP_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = q_rdata;
                    m_pos_next   = POS_W'(pop_idx_reg);
                    m_len_next   = LEN_W'(pop_len_reg);
                    m_last_next  = last_byte;
                    m_empty_next = 1'b0;
                    m_wait_next  = WAIT_W'(pop_left_reg);
                    if (last_byte) begin
                        state_next = ST_IDLE;
                    end else begin
                        pop_idx_next = pop_idx_reg + 1'b1;
                        state_next   = ST_POP_RD;
                    end
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = '0;
                    m_pos_next   = '0;
                    m_len_next   = '0;
                    m_last_next  = 1'b1;
                    m_empty_next = 1'b1;
                    m_wait_next  = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_WAIT;
            frame_len_reg <= '0;
            frame_idx_reg <= '0;
            sum_reg       <= '0;
            idle_reg      <= '0;
            timeout_reg   <= TIMEOUT_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            copy_cnt_reg  <= '0;
            pop_idx_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            frame_len_reg <= frame_len_next;
            frame_idx_reg <= frame_idx_next;
            sum_reg       <= sum_next;
            idle_reg      <= idle_next;
            timeout_reg   <= timeout_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            copy_cnt_reg  <= copy_cnt_next;
            pop_idx_reg   <= pop_idx_next;
            m_valid_reg   <= m_valid_next;
        end
        pop_slot_reg <= pop_slot_next;
        pop_len_reg  <= pop_len_next;
        pop_left_reg <= pop_left_next;
        lengths_reg  <= lengths_next;
        m_byte_reg   <= m_byte_next;
        m_pos_reg    <= m_pos_next;
        m_len_reg    <= m_len_next;
        m_last_reg   <= m_last_next;
        m_empty_reg  <= m_empty_next;
        m_wait_reg   <= m_wait_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_payload_byte     = m_byte_reg;
    assign m_byte_position    = m_pos_reg;
    assign m_message_length   = m_len_reg;
    assign m_last             = m_last_reg;
    assign m_queue_empty      = m_empty_reg;
    assign m_messages_waiting = m_wait_reg;

    `FPRQ_ASSERT_IMPLY(a_count_bound, aclk, aresetn, 1'b1,
        count_reg <= CNT_W'(QUEUE_DEPTH), "Queue count exceeds the queue depth.")
    `FPRQ_ASSERT_IMPLY(a_ptrs_meet, aclk, aresetn,
        (count_reg == '0) || (count_reg == CNT_W'(QUEUE_DEPTH)),
        head_reg == tail_reg, "Queue pointers disagree with an empty or full count.")
    `FPRQ_ASSERT_NEXT(a_commit_stores, aclk, aresetn,
        (state_reg == ST_COMMIT) && (copy_cnt_reg == frame_len_reg),
        (count_reg != '0) && (state_reg == ST_IDLE), "Committed frame left the queue empty.")
    `FPRQ_ASSERT_NEXT(a_pop_ends, aclk, aresetn,
        (state_reg == ST_POP_OUT) && out_free && last_byte,
        (state_reg == ST_IDLE) && m_valid_reg && m_last_reg,
        "Final byte of a pop did not end the transaction.")

endmodule

@@ tb/fprq_tb_pkg.sv @@
// Scoreboard of the framed packet receiver queue: predicts pop results and checks them.
`timescale 1ns / 1ps
package fprq_tb_pkg;
    import fprq_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        SEEK_START,
        SEEK_LENGTH,
        TAKE_PAYLOAD,
        TAKE_CHECKSUM,
        SEEK_END
    } parse_state_t;

    typedef struct packed {
        logic [7:0]        payload_byte;
        logic [POS_W-1:0]  byte_position;
        logic [LEN_W-1:0]  message_length;
        logic              last;
        logic              queue_empty;
        logic [WAIT_W-1:0] messages_waiting;
    } pop_result_t;

    class frame_queue_checker_t;
        logic [15:0]  timeout_ticks;
        parse_state_t parse_state;
        int           frame_len;
        int           frame_fill;
        logic [7:0]   frame_sum;
        int           idle_ticks;
        logic [7:0]   frame_bytes[BUFFER_BYTES];
        logic [7:0]   stored_bytes[QUEUE_DEPTH][BUFFER_BYTES];
        int           stored_len[QUEUE_DEPTH];
        int           write_slot;
        int           read_slot;
        int           stored_count;
        pop_result_t  expected_pops[$];
        int           errors;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            parse_state = SEEK_START;
            frame_len = 0;
            frame_fill = 0;
            frame_sum = 8'h00;
            idle_ticks = 0;
            write_slot = 0;
            read_slot = 0;
            stored_count = 0;
            errors = 0;
        endfunction

        function void set_timeout(logic [15:0] value);
            timeout_ticks = value;
        endfunction

        function int pending();
            return expected_pops.size();
        endfunction

        // A full queue loses its oldest message to make room.
        function void queue_frame();
            if (stored_count >= QUEUE_DEPTH) begin
                read_slot = (read_slot + 1) % QUEUE_DEPTH;
                stored_count--;
            end
            stored_bytes[write_slot] = frame_bytes;
            stored_len[write_slot] = frame_len;
            write_slot = (write_slot + 1) % QUEUE_DEPTH;
            stored_count++;
        endfunction

        function void parse_byte(logic [7:0] data);
            idle_ticks = 0;
            case (parse_state)
                SEEK_START: begin
                    if (data == START_BYTE) parse_state = SEEK_LENGTH;
                end
                SEEK_LENGTH: begin
                    if (data == 8'd0 || int'(data) > BUFFER_BYTES - 1) begin
                        parse_state = SEEK_START;
                    end else begin
                        frame_len = int'(data);
                        frame_fill = 0;
                        frame_sum = 8'h00;
                        parse_state = TAKE_PAYLOAD;
                    end
                end
                TAKE_PAYLOAD: begin
                    frame_bytes[frame_fill] = data;
                    frame_fill++;
                    frame_sum += data;
                    if (frame_fill >= frame_len) parse_state = TAKE_CHECKSUM;
                end
                TAKE_CHECKSUM: begin
                    frame_sum += data;
                    parse_state = SEEK_END;
                end
                default: begin
                    if (data == END_BYTE && frame_sum == 8'h00) queue_frame();
                    parse_state = SEEK_START;
                end
            endcase
        endfunction

        function void count_tick();
            if (idle_ticks < 16'hFFFF) idle_ticks++;
            if (parse_state != SEEK_START && idle_ticks > timeout_ticks) begin
                parse_state = SEEK_START;
            end
        endfunction

        function void unload_message();
            pop_result_t r;
            int slot;
            int len;
            if (stored_count == 0) begin
                r = '0;
                r.last = 1'b1;
                r.queue_empty = 1'b1;
                expected_pops.push_back(r);
                return;
            end
            slot = read_slot;
            len = stored_len[slot];
            read_slot = (read_slot + 1) % QUEUE_DEPTH;
            stored_count--;
            for (int i = 0; i < len; i++) begin
                r.payload_byte = stored_bytes[slot][i];
                r.byte_position = POS_W'(i);
                r.message_length = LEN_W'(len);
                r.last = (i == len - 1);
                r.queue_empty = 1'b0;
                r.messages_waiting = WAIT_W'(stored_count);
                expected_pops.push_back(r);
            end
        endfunction

        function void take_request(logic [1:0] req, logic [7:0] data);
            case (req)
                REQ_BYTE: parse_byte(data);
                REQ_TICK: count_tick();
                REQ_POP:  unload_message();
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_pop_result(pop_result_t got);
            pop_result_t want;
            if (expected_pops.size() == 0) begin
                $error("unexpected pop result with payload_byte %0d", got.payload_byte);
                errors++;
                return;
            end
            want = expected_pops.pop_front();
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("byte_position", 8'(want.byte_position), 8'(got.byte_position));
            compare_field("message_length", 8'(want.message_length),
                          8'(got.message_length));
            compare_field("last", 8'(want.last), 8'(got.last));
            compare_field("queue_empty", 8'(want.queue_empty), 8'(got.queue_empty));
            compare_field("messages_waiting", 8'(want.messages_waiting),
                          8'(got.messages_waiting));
        endfunction
    endclass

endpackage

@@ tb/tb_top.sv @@
// Top-level testbench of the framed packet receiver queue.
`timescale 1ns / 1ps
module tb_top;
    import fprq_pkg::*;
    import fprq_tb_pkg::*;

    typedef enum int {FRAME_OK, FRAME_BAD_SUM, FRAME_BAD_END} frame_fault_t;
    typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES} frame_fill_t;

    localparam int DRAIN_CYCLES     = 2 * BUFFER_BYTES + 8;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int RANDOM_ITEMS     = 290;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_req_type;
    logic [7:0]            s_rx_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_payload_byte;
    logic [POS_W-1:0]      m_byte_position;
    logic [LEN_W-1:0]      m_message_length;
    logic                  m_last;
    logic                  m_queue_empty;
    logic [WAIT_W-1:0]     m_messages_waiting;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    frame_queue_checker_t queue_check;
    int                   items_sent = 0;
    bit                   source_gaps = 1'b1;
    bit                   sink_stalls = 1'b1;
    bit                   hold_off_req = 1'b0;

    framed_packet_receiver_queue DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_req_type         (s_req_type),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_payload_byte     (m_payload_byte),
        .m_byte_position    (m_byte_position),
        .m_message_length   (m_message_length),
        .m_last             (m_last),
        .m_queue_empty      (m_queue_empty),
        .m_messages_waiting (m_messages_waiting),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                queue_check.check_pop_result(pop_result_t'({m_payload_byte, m_byte_position,
                    m_message_length, m_last, m_queue_empty, m_messages_waiting}));
            end
            if (s_valid && s_ready) queue_check.take_request(s_req_type, s_rx_byte);
        end
    end

    // Result sink: random stalls per transaction, plus one long hold-off on request.
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end
            gap = sink_stalls ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_item(input logic [1:0] req, input logic [7:0] data);
        int gap;
        gap = source_gaps ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_rx_byte <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(REQ_TICK, 8'($urandom));
    endtask

    task automatic maybe_ticks(input int tick_pct);
        if ($urandom_range(0, 99) < tick_pct) send_ticks($urandom_range(1, 10));
    endtask

    // Lengths outside 1..BUFFER_BYTES-1 are sent as given and followed by two filler bytes.
    task automatic send_frame(input int len_byte, input frame_fault_t fault,
                              input frame_fill_t fill, input int tick_pct);
        logic [7:0] data;
        logic [7:0] sum;
        int         count;
        sum = 8'h00;
        send_item(REQ_BYTE, START_BYTE);
        maybe_ticks(tick_pct);
        send_item(REQ_BYTE, 8'(len_byte));
        count = (len_byte >= 1 && len_byte < BUFFER_BYTES) ? len_byte : 2;
        for (int i = 0; i < count; i++) begin
            case (fill)
                FILL_ZEROS: data = 8'h00;
                FILL_ONES:  data = 8'hFF;
                default:    data = 8'($urandom);
            endcase
            sum += data;
            maybe_ticks(tick_pct);
            send_item(REQ_BYTE, data);
        end
        data = -sum;
        if (fault == FRAME_BAD_SUM) data += 8'($urandom_range(1, 255));
        send_item(REQ_BYTE, data);
        if (fault == FRAME_BAD_END) begin
            send_item(REQ_BYTE, END_BYTE ^ 8'($urandom_range(1, 255)));
        end else begin
            send_item(REQ_BYTE, END_BYTE);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (queue_check.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_timeout_reg(input logic [15:0] value);
        logic [31:0] readback;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_TIMEOUT, 2'b00};
        pwdata <= {16'h0000, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        queue_check.set_timeout(value);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        readback = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback[15:0] !== value) begin
            $error("timeout_ticks: expected %0d, got %0d", value, readback[15:0]);
            queue_check.errors++;
        end
    endtask

    initial begin
        int          start_count;
        int          pick;
        int          len_byte;
        logic [15:0] phase_timeout[4];

        queue_check = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = REQ_BYTE;
        s_rx_byte = 8'h00;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = 32'h0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty pops, extreme frames, bad lengths, bad checksum, bad end byte, full queue.
        send_item(REQ_POP, 8'h00);
        send_frame(1, FRAME_OK, FILL_ZEROS, 0);
        send_item(REQ_POP, 8'hFF);
        send_frame(BUFFER_BYTES - 1, FRAME_OK, FILL_ONES, 0);
        send_frame(0, FRAME_OK, FILL_RANDOM, 0);
        send_frame(BUFFER_BYTES, FRAME_OK, FILL_RANDOM, 0);
        send_frame(255, FRAME_OK, FILL_RANDOM, 0);
        send_frame(3, FRAME_BAD_SUM, FILL_RANDOM, 0);
        send_frame(3, FRAME_BAD_END, FILL_RANDOM, 0);
        send_item(REQ_UNUSED, 8'hA5);
        send_item(REQ_POP, 8'h00);
        send_item(REQ_POP, 8'h00);
        repeat (QUEUE_DEPTH + 1) send_frame($urandom_range(1, 6), FRAME_OK, FILL_RANDOM, 0);
        repeat (QUEUE_DEPTH + 1) send_item(REQ_POP, 8'h00);

        // Idle ticks exactly at the timeout keep the frame; one more drops it.
        settle();
        write_timeout_reg(16'd3);
        for (int ticks = 3; ticks <= 4; ticks++) begin
            send_item(REQ_BYTE, START_BYTE);
            send_item(REQ_BYTE, 8'd1);
            send_ticks(ticks);
            send_item(REQ_BYTE, 8'h80);
            send_item(REQ_BYTE, 8'h80);
            send_item(REQ_BYTE, END_BYTE);
        end
        send_item(REQ_POP, 8'h00);
        send_item(REQ_POP, 8'h00);

        phase_timeout = '{16'd0, 16'hFFFF, 16'd8, 16'($urandom_range(1, 40))};
        for (int phase = 0; phase < 4; phase++) begin
            settle();
            write_timeout_reg(phase_timeout[phase]);
            if (phase == 2) begin
                send_frame(BUFFER_BYTES - 1, FRAME_OK, FILL_RANDOM, 0);
                hold_off_req = 1'b1;
                send_item(REQ_POP, 8'h00);
            end
            start_count = items_sent;
            while (items_sent - start_count < RANDOM_ITEMS / 4) begin
                if ($urandom_range(0, 11) == 0) begin
                    source_gaps = $urandom_range(0, 2) != 0;
                    sink_stalls = $urandom_range(0, 2) != 0;
                end
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    len_byte = ($urandom_range(0, 9) == 0) ? $urandom_range(1, BUFFER_BYTES - 1)
                                                           : $urandom_range(1, 6);
                    send_frame(len_byte, FRAME_OK, FILL_RANDOM, 8);
                end else if (pick < 60) begin
                    if ($urandom_range(0, 2) == 0) begin
                        len_byte = $urandom_range(0, 1) ? 0 : $urandom_range(BUFFER_BYTES, 255);
                        send_frame(len_byte, FRAME_OK, FILL_RANDOM, 8);
                    end else begin
                        send_frame($urandom_range(1, 6), frame_fault_t'($urandom_range(1, 2)),
                                   FILL_RANDOM, 8);
                    end
                end else if (pick < 82) begin
                    send_item(REQ_POP, 8'($urandom));
                end else if (pick < 92) begin
                    send_ticks($urandom_range(1, 12));
                end else begin
                    send_item($urandom_range(0, 1) ? REQ_UNUSED : REQ_BYTE, 8'($urandom));
                end
            end
        end

        settle();
        if (queue_check.errors == 0 && queue_check.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ framed_packet_receiver_queue.f @@
+incdir+src
src/fprq_pkg.sv
src/fprq_ram.sv
src/framed_packet_receiver_queue.sv
tb/fprq_tb_pkg.sv
tb/tb_top.sv
